### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent on this edge implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("label failed");
// antecedent implies consequent on the same edge
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("label failed");
`endif

### rtl/core/ahc_pkg.sv
// package of types and constants for the adjacent hit clusterer
package ahc_pkg;
  localparam int HITS_PER_KIND = 32;
  localparam int CHANNEL_BITS = 24;
  localparam int NUM_BITS = 5;

  typedef struct packed {
    logic        is_strip;
    logic [2:0]  wire_req;
    logic [6:0]  box_number;
    logic [6:0]  layer;
    logic [3:0]  sector;
    logic [3:0]  module_req;
    logic [23:0] strip_channel;
    logic        last_hit;
  } hit_t;

  typedef struct packed {
    logic        cluster_is_strip;
    logic [4:0]  cluster_number;
    logic [4:0]  hit_number;
    logic [23:0] channel_id;
    logic        last_in_cluster;
    logic        last_of_event;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_INSERT, S_CHECK, S_BOX, S_STRIP, S_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic insert;
    logic clear;
    logic start;
    logic emit;
    logic kind;
    logic event_end;
  } cmd_t;

  typedef struct packed {
    logic last_hit;
    logic both_nonempty;
    logic slot_free;
    logic kind_end;
  } status_t;
endpackage

### rtl/core/ahc_store.sv
// sorted channel store for one hit kind
module ahc_store #(
  parameter int N = ahc_pkg::HITS_PER_KIND,
  parameter int CB = ahc_pkg::CHANNEL_BITS,
  localparam int IW = $clog2(N),
  localparam int CW = $clog2(N + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         insert,
  input  logic                         clear,
  input  logic [CB-1:0]                chan_in,
  input  logic [IW-1:0]                idx,
  output logic [CW-1:0]                count,
  output logic [CB-1:0]                rd_chan,
  output logic [ahc_pkg::NUM_BITS-1:0] rd_num,
  output logic                         rd_end
);
  logic [CB-1:0]                chans [N];
  logic [ahc_pkg::NUM_BITS-1:0] nums [N];
  logic [CW-1:0]                arrivals;
  logic [N-1:0]                 valid, lt, eq, ins, shift, adj;
  logic                         drop, match, full;
  logic [ahc_pkg::NUM_BITS-1:0] num_new;

  assign drop    = (arrivals == CW'(N));
  assign full    = (count == CW'(N));
  assign match   = |eq;
  assign num_new = ahc_pkg::NUM_BITS'(arrivals);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      valid[k] = CW'(k) < count;
      lt[k]    = valid[k] && (chans[k] < chan_in);
      eq[k]    = valid[k] && (chans[k] == chan_in);
    end
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        ins[k]   = !lt[k];
        shift[k] = 1'b0;
      end else begin
        ins[k]   = lt[k-1] && !lt[k];
        shift[k] = !lt[k-1] && valid[k-1];
      end
    end
    for (int k = 0; k < N; k++) begin
      if (k == N - 1) begin
        adj[k] = 1'b0;
      end else begin
        adj[k] = ({1'b0, chans[k+1]} == ({1'b0, chans[k]} + (CB+1)'(1)));
      end
    end
  end

  assign rd_chan = chans[idx];
  assign rd_num  = nums[idx];
  assign rd_end  = ((CW'(idx) + CW'(1)) == count) || !adj[idx];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count    <= '0;
      arrivals <= '0;
    end else if (insert && !drop) begin
      arrivals <= arrivals + CW'(1);
      if (!match && !full) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (insert && !drop) begin
      for (int k = 0; k < N; k++) begin
        if (match) begin
          if (eq[k]) nums[k] <= num_new;
        end else if (!full) begin
          if (ins[k]) begin
            chans[k] <= chan_in;
            nums[k]  <= num_new;
          end else if (shift[k]) begin
            chans[k] <= chans[k-1];
            nums[k]  <= nums[k-1];
          end
        end
      end
    end
  end
endmodule

### rtl/core/ahc_datapath.sv
// input register, channel arithmetic, stores and result register
module ahc_datapath #(
  parameter int N = ahc_pkg::HITS_PER_KIND,
  parameter int CB = ahc_pkg::CHANNEL_BITS,
  localparam int IW = $clog2(N),
  localparam int CW = $clog2(N + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  ahc_pkg::cmd_t       cmd,
  output ahc_pkg::status_t    status,
  input  ahc_pkg::hit_t       hit,
  output logic                result_valid,
  input  logic                result_ready,
  output ahc_pkg::result_t    result
);
  ahc_pkg::hit_t                in_reg;
  logic [CB-1:0]                chan_reg;
  logic [31:0]                  chan_full;
  logic [IW-1:0]                idx;
  logic [4:0]                   cluster;
  logic [CW-1:0]                box_count, strip_count;
  logic [CB-1:0]                box_chan, strip_chan, sel_chan;
  logic [ahc_pkg::NUM_BITS-1:0] box_num, strip_num;
  logic                         box_end, strip_end, sel_end, kind_end;
  logic [CW-1:0]                sel_count;
  logic [31:0]                  chan_wide;

  always_comb begin
    if (in_reg.is_strip) begin
      chan_full = 32'(in_reg.strip_channel);
    end else begin
      chan_full = 32'(in_reg.wire_req) + {22'd0, in_reg.box_number, 3'd0}
                + 32'(in_reg.layer) * 32'd1000
                + 32'(in_reg.sector) * 32'd100000
                + 32'(in_reg.module_req) * 32'd1000000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_reg <= hit;
    if (cmd.calc) chan_reg <= chan_full[CB-1:0];
  end

  ahc_store #(.N(N), .CB(CB)) u_box (
    .clk(clk), .rst(rst), .insert(cmd.insert && !in_reg.is_strip), .clear(cmd.clear),
    .chan_in(chan_reg), .idx(idx), .count(box_count), .rd_chan(box_chan),
    .rd_num(box_num), .rd_end(box_end)
  );

  ahc_store #(.N(N), .CB(CB)) u_strip (
    .clk(clk), .rst(rst), .insert(cmd.insert && in_reg.is_strip), .clear(cmd.clear),
    .chan_in(chan_reg), .idx(idx), .count(strip_count), .rd_chan(strip_chan),
    .rd_num(strip_num), .rd_end(strip_end)
  );

  assign sel_count = cmd.kind ? strip_count : box_count;
  assign sel_chan  = cmd.kind ? strip_chan : box_chan;
  assign sel_end   = cmd.kind ? strip_end : box_end;
  assign kind_end  = (CW'(idx) + CW'(1)) == sel_count;
  assign chan_wide = 32'(sel_chan);

  assign status.last_hit      = in_reg.last_hit;
  assign status.both_nonempty = (box_count != '0) && (strip_count != '0);
  assign status.slot_free     = !result_valid || result_ready;
  assign status.kind_end      = kind_end;

  always_ff @(posedge clk) begin
    if (cmd.start || (cmd.emit && kind_end)) begin
      idx     <= '0;
      cluster <= '0;
    end else if (cmd.emit) begin
      idx     <= idx + IW'(1);
      cluster <= cluster + 5'(sel_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.cluster_is_strip <= cmd.kind;
      result.cluster_number   <= cluster;
      result.hit_number       <= cmd.kind ? strip_num : box_num;
      result.channel_id       <= chan_wide[23:0];
      result.last_in_cluster  <= sel_end;
      result.last_of_event    <= cmd.event_end && kind_end;
    end
  end
endmodule

### rtl/core/ahc_ctrl.sv
// controller state machine of the adjacent hit clusterer
module ahc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             hit_valid,
  output logic             hit_ready,
  input  ahc_pkg::status_t status,
  output ahc_pkg::cmd_t    cmd
);
  ahc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ahc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ahc_pkg::S_IDLE:   if (hit_valid) state_next = ahc_pkg::S_CALC;
      ahc_pkg::S_CALC:   state_next = ahc_pkg::S_INSERT;
      ahc_pkg::S_INSERT: state_next = status.last_hit ? ahc_pkg::S_CHECK : ahc_pkg::S_IDLE;
      ahc_pkg::S_CHECK:  state_next = status.both_nonempty ? ahc_pkg::S_BOX : ahc_pkg::S_CLEAR;
      ahc_pkg::S_BOX:    if (status.slot_free && status.kind_end) state_next = ahc_pkg::S_STRIP;
      ahc_pkg::S_STRIP:  if (status.slot_free && status.kind_end) state_next = ahc_pkg::S_CLEAR;
      ahc_pkg::S_CLEAR:  state_next = ahc_pkg::S_IDLE;
      default:           state_next = ahc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    hit_ready = 1'b0;
    unique case (state)
      ahc_pkg::S_IDLE: begin
        hit_ready = 1'b1;
        cmd.load  = hit_valid;
      end
      ahc_pkg::S_CALC:   cmd.calc = 1'b1;
      ahc_pkg::S_INSERT: cmd.insert = 1'b1;
      ahc_pkg::S_CHECK:  cmd.start = 1'b1;
      ahc_pkg::S_BOX:    cmd.emit = status.slot_free;
      ahc_pkg::S_STRIP: begin
        cmd.kind      = 1'b1;
        cmd.event_end = 1'b1;
        cmd.emit      = status.slot_free;
      end
      ahc_pkg::S_CLEAR:  cmd.clear = 1'b1;
      default:           cmd = '0;
    endcase
  end
endmodule

### rtl/core/adjacent_hit_clusterer.sv
// top level of the adjacent hit clusterer
// usage:
//   hits enter on hit/hit_valid/hit_ready, one item per handshake. each item
//   passes the register, channel arithmetic and sorted insert steps in turn;
//   hit_ready is high only while the block waits for an item, so a hit is
//   taken only once the previous one is inserted. an item with last_hit set
//   adds a check state, then, if both kinds hold hits, the members are
//   emitted on result/result_valid/result_ready, box kind first, ascending
//   channel, one item per cycle while the receiver takes them, followed by a
//   state that clears the counts. the insert rate is set by the load, calc
//   and insert states, the emission rate by the single result register.
//   the box state that follows the check state registers the first result.
//   a stalled receiver holds the result register and pauses emission; the
//   final result may still wait while the next event's first hit is taken.
//   reset clears the counts, state and result_valid; store contents are
//   never read before being written.
`include "assert_macros.svh"
module adjacent_hit_clusterer #(
  parameter int HITS_PER_KIND = ahc_pkg::HITS_PER_KIND,
  parameter int CHANNEL_BITS = ahc_pkg::CHANNEL_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             hit_valid,
  output logic             hit_ready,
  input  ahc_pkg::hit_t    hit,
  output logic             result_valid,
  input  logic             result_ready,
  output ahc_pkg::result_t result
);
  ahc_pkg::cmd_t    cmd;
  ahc_pkg::status_t status;

  ahc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .hit_valid(hit_valid), .hit_ready(hit_ready),
    .status(status), .cmd(cmd)
  );

  ahc_datapath #(.N(HITS_PER_KIND), .CB(CHANNEL_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .hit(hit),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  `ASSERT_NEXT(a_one_hit_at_a_time, clk, rst, hit_valid && hit_ready, !hit_ready)
  `ASSERT_SAME(a_event_end_closes_cluster, clk, rst,
               result_valid && result.last_of_event, result.last_in_cluster)
  `ASSERT_SAME(a_event_end_is_strip, clk, rst,
               result_valid && result.last_of_event, result.cluster_is_strip)
endmodule

### test/tb_top.sv
// testbench for the adjacent hit clusterer: random and directed events checked against a predictor
module tb_top;

  class cluster_scoreboard;
    logic [23:0]       box_chan[ahc_pkg::HITS_PER_KIND];
    logic [4:0]        box_num[ahc_pkg::HITS_PER_KIND];
    int                box_cnt, box_arr;
    logic [23:0]       strip_chan[ahc_pkg::HITS_PER_KIND];
    logic [4:0]        strip_num[ahc_pkg::HITS_PER_KIND];
    int                strip_cnt, strip_arr;
    ahc_pkg::result_t  pending[$];
    int                mismatches, results_seen, events_emitted;

    function void store(bit strip, logic [23:0] ch);
      int num;
      if (strip) begin
        if (strip_arr >= ahc_pkg::HITS_PER_KIND) return;
        num = strip_arr;
        strip_arr++;
        for (int i = 0; i < strip_cnt; i++)
          if (strip_chan[i] == ch) begin
            strip_num[i] = 5'(num);
            return;
          end
        strip_chan[strip_cnt] = ch;
        strip_num[strip_cnt] = 5'(num);
        strip_cnt++;
      end else begin
        if (box_arr >= ahc_pkg::HITS_PER_KIND) return;
        num = box_arr;
        box_arr++;
        for (int i = 0; i < box_cnt; i++)
          if (box_chan[i] == ch) begin
            box_num[i] = 5'(num);
            return;
          end
        box_chan[box_cnt] = ch;
        box_num[box_cnt] = 5'(num);
        box_cnt++;
      end
    endfunction

    function void emit_kind(bit strip);
      int n, cl, tmp;
      int ord[ahc_pkg::HITS_PER_KIND];
      logic [23:0] chs[ahc_pkg::HITS_PER_KIND];
      logic [4:0]  nums[ahc_pkg::HITS_PER_KIND];
      ahc_pkg::result_t r;
      n = strip ? strip_cnt : box_cnt;
      for (int i = 0; i < n; i++) begin
        chs[i] = strip ? strip_chan[i] : box_chan[i];
        nums[i] = strip ? strip_num[i] : box_num[i];
        ord[i] = i;
      end
      for (int i = 1; i < n; i++)
        for (int j = i; j > 0 && chs[ord[j-1]] > chs[ord[j]]; j--) begin
          tmp = ord[j]; ord[j] = ord[j-1]; ord[j-1] = tmp;
        end
      cl = 0;
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.cluster_is_strip = strip;
        r.cluster_number = cl[4:0];
        r.hit_number = nums[ord[i]];
        r.channel_id = chs[ord[i]];
        r.last_in_cluster = (i + 1 == n) ||
          ({1'b0, chs[ord[i+1]]} != {1'b0, chs[ord[i]]} + 25'd1);
        pending = {pending, r};
        if (r.last_in_cluster) cl++;
      end
    endfunction

    function void note_hit(ahc_pkg::hit_t h);
      logic [31:0] ch;
      if (h.is_strip) store(1, h.strip_channel);
      else begin
        ch = h.wire_req + 8 * h.box_number + 1000 * h.layer + 100000 * h.sector
             + 1000000 * h.module_req;
        store(0, ch[23:0]);
      end
      if (!h.last_hit) return;
      if (box_cnt > 0 && strip_cnt > 0) begin
        emit_kind(0);
        emit_kind(1);
        pending[$].last_of_event = 1'b1;
        events_emitted++;
      end
      box_cnt = 0; strip_cnt = 0; box_arr = 0; strip_arr = 0;
    endfunction

    function void check_result(ahc_pkg::result_t got);
      ahc_pkg::result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic             clk = 0, rst = 1;
  logic             hit_valid = 0, hit_ready, result_valid, result_ready = 0;
  ahc_pkg::hit_t    hit = '0;
  ahc_pkg::result_t result;
  bit               calm = 0;
  bit               hits_done = 0;
  cluster_scoreboard sb = new();

  adjacent_hit_clusterer dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk)
    if (!rst && result_valid && result_ready) sb.check_result(result);

  // receiver stalls in bursts
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      result_ready = 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 14);
        result_ready = 0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  task automatic send_hit(ahc_pkg::hit_t h);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 14)) @(negedge clk);
    hit = h;
    hit_valid = 1;
    @(posedge clk);
    while (!hit_ready) @(posedge clk);
    sb.note_hit(h);
    @(negedge clk);
    hit_valid = 0;
  endtask

  function automatic ahc_pkg::hit_t box_hit(int w, int b, int l, int s, int m, bit last);
    ahc_pkg::hit_t h;
    h = '0;
    h.is_strip = 0; h.wire_req = 3'(w); h.box_number = 7'(b); h.layer = 7'(l);
    h.sector = 4'(s); h.module_req = 4'(m); h.last_hit = last;
    h.strip_channel = 24'($urandom);
    return h;
  endfunction

  function automatic ahc_pkg::hit_t strip_hit(int ch, bit last);
    ahc_pkg::hit_t h;
    h = ahc_pkg::hit_t'({$urandom, $urandom});
    h.is_strip = 1; h.strip_channel = 24'(ch); h.last_hit = last;
    return h;
  endfunction

  task automatic random_event(int nhits, int base, int span);
    ahc_pkg::hit_t h;
    for (int i = 0; i < nhits; i++) begin
      if ($urandom_range(0, 1)) h = strip_hit(base + $urandom_range(0, span), 0);
      else h = box_hit($urandom_range(0, 7), $urandom_range(0, 3),
                       $urandom_range(0, 1), 0, 0, 0);
      if ($urandom_range(0, 9) == 0) h = ahc_pkg::hit_t'({$urandom, $urandom});
      h.last_hit = (i == nhits - 1);
      send_hit(h);
    end
  endtask

  initial begin
    int sent;
    repeat (10) @(negedge clk);
    rst = 0;
    // directed: extremes, duplicates, wrap-free top, empty kinds
    send_hit(box_hit(7, 127, 127, 15, 15, 0));
    send_hit(box_hit(0, 0, 0, 0, 0, 0));
    send_hit(box_hit(1, 0, 0, 0, 0, 0));
    send_hit(box_hit(0, 0, 0, 0, 0, 0));
    send_hit(strip_hit(24'hFFFFFF, 0));
    send_hit(strip_hit(0, 0));
    send_hit(strip_hit(24'hFFFFFE, 1));
    send_hit(strip_hit(5, 1));
    send_hit(box_hit(3, 2, 1, 0, 0, 1));
    send_hit(strip_hit(9, 0));
    send_hit(box_hit(3, 99, 99, 9, 9, 1));
    // store full: 40 strip hits then 40 box hits
    for (int i = 0; i < 40; i++) send_hit(strip_hit(100 + (i % 35), 0));
    for (int i = 0; i < 40; i++) send_hit(box_hit(i % 8, i / 8, 0, 0, 0, i == 39));
    sent = 91;
    while (sent < 450) begin
      int n;
      n = $urandom_range(1, 12);
      if (sent > 380) calm = 1;
      random_event(n, $urandom_range(0, 1) ? $urandom_range(0, 50) : $urandom, 8);
      sent += n;
    end
    hits_done = 1;
  end

  initial begin
    wait (hits_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d results checked over %0d emitting events, including store overflow",
             sb.results_seen, sb.events_emitted);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
